// ----- design/polynomial_arctan_degrees_defines.svh -----
// ----------------------------------------------------------------------------
// polynomial arctangent assertion macros
// concurrent assertion wrappers clocked on clk_i, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_ARCTAN_DEGREES_DEFINES_SVH
`define POLYNOMIAL_ARCTAN_DEGREES_DEFINES_SVH

// checked only while out of reset
`define PAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define PAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/polyarc_pkg.sv -----
// ----------------------------------------------------------------------------
// polyarc_pkg
// shared widths, item type and Horner coefficients for the arctangent chain
// ----------------------------------------------------------------------------
package polyarc_pkg;

  localparam int IN_W     = 24;
  localparam int OUT_W    = 24;
  localparam int MAG_W    = 24;
  localparam int ACC_W    = 46;
  localparam int ACC_FRAC = 32;
  localparam int HI_W     = 13;
  localparam int LO_W     = 32;
  localparam int STEPS    = 5;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [MAG_W-1:0]        mag_t;

  typedef struct packed {
    mag_t mag;
    logic neg;
    logic high;
    acc_t acc;
  } item_t;

  // 4096 with 32 fraction bits
  localparam acc_t ACC_LIMIT = 46'sh100000000000;

  // leading coefficient of the high-range polynomial
  localparam acc_t HIGH_LEAD = 46'sd92266;

  // coefficient added at each step, low range starts from a zero accumulator
  localparam acc_t COEF_LOW [STEPS] = '{
    -46'sd1300059929,
    46'sd18441343170,
    -46'sd101691248748,
    46'sd276561081005,
    46'sd0
  };

  localparam acc_t COEF_HIGH [STEPS] = '{
    -46'sd7573982,
    46'sd245981955,
    -46'sd4015995297,
    46'sd34516195437,
    46'sd238907594495
  };

endpackage

// ----- design/polyarc_cell.sv -----
// ----------------------------------------------------------------------------
// polyarc_cell
// one Horner step: acc * t truncated toward zero, plus coefficient, saturated
// ----------------------------------------------------------------------------
module polyarc_cell #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  polyarc_pkg::item_t  item_i,
  input  polyarc_pkg::acc_t   coef_low_i,
  input  polyarc_pkg::acc_t   coef_high_i,
  output logic                valid_o,
  input  logic                stall_i,
  output polyarc_pkg::item_t  item_o
);

  localparam int PH_W  = polyarc_pkg::HI_W + polyarc_pkg::MAG_W;
  localparam int PL_W  = polyarc_pkg::LO_W + polyarc_pkg::MAG_W;
  localparam int RW    = PH_W + polyarc_pkg::LO_W - FRAC_BITS + 1;
  localparam int SW    = RW + 1;
  localparam int SH_HI = polyarc_pkg::LO_W - FRAC_BITS;

  // stage a: partial products
  logic                          a_vld_q;
  polyarc_pkg::item_t            a_item_q;
  logic                          a_neg_q;
  logic [PH_W-1:0]               pp_hi_q;
  logic [PL_W-1:0]               pp_lo_q;
  logic                          acc_neg;
  logic [polyarc_pkg::ACC_W-1:0] acc_mag;
  logic [polyarc_pkg::HI_W-1:0]  acc_hi;
  logic [polyarc_pkg::LO_W-1:0]  acc_lo;
  logic [PH_W-1:0]               pp_hi_d;
  logic [PL_W-1:0]               pp_lo_d;
  logic                          a_en;

  // stage b: combine, add coefficient, saturate
  logic                          b_vld_q;
  polyarc_pkg::item_t            b_item_q;
  polyarc_pkg::item_t            b_item_d;
  logic [RW-1:0]                 prod;
  logic signed [SW-1:0]          prod_ext;
  logic signed [SW-1:0]          coef_ext;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          lim_pos;
  logic signed [SW-1:0]          lim_neg;
  polyarc_pkg::acc_t             acc_d;
  logic                          b_en;

  assign b_en    = !b_vld_q || !stall_i;
  assign a_en    = !a_vld_q || b_en;
  assign stall_o = !a_en;

  assign acc_neg = item_i.acc[polyarc_pkg::ACC_W-1];
  assign acc_mag = acc_neg ? polyarc_pkg::ACC_W'(-item_i.acc)
                           : polyarc_pkg::ACC_W'(item_i.acc);
  assign acc_hi  = acc_mag[polyarc_pkg::LO_W +: polyarc_pkg::HI_W];
  assign acc_lo  = acc_mag[polyarc_pkg::LO_W-1:0];
  assign pp_hi_d = PH_W'(acc_hi) * PH_W'(item_i.mag);
  assign pp_lo_d = PL_W'(acc_lo) * PL_W'(item_i.mag);

  assign prod     = (RW'(pp_hi_q) << SH_HI) + RW'(pp_lo_q >> FRAC_BITS);
  assign prod_ext = $signed({1'b0, prod});
  assign coef_ext = a_item_q.high ? SW'(coef_high_i) : SW'(coef_low_i);
  assign sum      = a_neg_q ? (coef_ext - prod_ext) : (coef_ext + prod_ext);
  assign lim_pos  = SW'(polyarc_pkg::ACC_LIMIT);
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (sum > lim_pos) begin
      acc_d = polyarc_pkg::ACC_LIMIT;
    end else if (sum < lim_neg) begin
      acc_d = -polyarc_pkg::ACC_LIMIT;
    end else begin
      acc_d = polyarc_pkg::ACC_W'(sum);
    end
  end

  always_comb begin
    b_item_d     = a_item_q;
    b_item_d.acc = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_vld_q <= valid_i;
      end
      if (b_en) begin
        b_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && valid_i) begin
      a_item_q <= item_i;
      a_neg_q  <= acc_neg;
      pp_hi_q  <= pp_hi_d;
      pp_lo_q  <= pp_lo_d;
    end
    if (b_en && a_vld_q) begin
      b_item_q <= b_item_d;
    end
  end

  assign valid_o = b_vld_q;
  assign item_o  = b_item_q;

endmodule

// ----- design/polyarc_finish.sv -----
// ----------------------------------------------------------------------------
// polyarc_finish
// rounds the accumulator, clamps to 90 degrees, applies sign, saturates
// ----------------------------------------------------------------------------
module polyarc_finish #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  polyarc_pkg::item_t                  item_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [polyarc_pkg::OUT_W-1:0] angle_deg_o
);

  localparam int AW = polyarc_pkg::ACC_W;
  localparam int OW = polyarc_pkg::OUT_W;
  localparam int SH = polyarc_pkg::ACC_FRAC - FRAC_BITS;
  localparam logic [AW-1:0] HALF    = AW'(1) << (SH - 1);
  localparam logic [AW-1:0] QUARTER = AW'(90) << FRAC_BITS;
  localparam logic [AW-1:0] NEG_MAX = AW'(1) << (OW - 1);
  localparam logic [AW-1:0] POS_MAX = NEG_MAX - AW'(1);

  logic          acc_neg;
  logic [AW-1:0] acc_mag;
  logic [AW-1:0] rnd_d;
  logic          r_en;
  logic          r_vld_q;
  logic [AW-1:0] rmag_q;
  logic          rneg_q;
  logic          tneg_q;

  logic          o_en;
  logic          o_vld_q;
  logic [AW-1:0] mag_c;
  logic          out_neg;
  logic [OW-1:0] ang_d;
  logic [OW-1:0] ang_q;

  assign o_en    = !o_vld_q || !stall_i;
  assign r_en    = !r_vld_q || o_en;
  assign stall_o = !r_en;

  assign acc_neg = item_i.acc[AW-1];
  assign acc_mag = acc_neg ? AW'(-item_i.acc) : AW'(item_i.acc);
  assign rnd_d   = (acc_mag + HALF) >> SH;

  assign mag_c   = (!rneg_q && (rmag_q > QUARTER)) ? QUARTER : rmag_q;
  assign out_neg = rneg_q ^ tneg_q;

  always_comb begin
    if (out_neg) begin
      ang_d = (mag_c > NEG_MAX) ? -OW'(NEG_MAX) : -OW'(mag_c);
    end else begin
      ang_d = (mag_c > POS_MAX) ? OW'(POS_MAX) : OW'(mag_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (r_en) begin
        r_vld_q <= valid_i;
      end
      if (o_en) begin
        o_vld_q <= r_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_en && valid_i) begin
      rmag_q <= rnd_d;
      rneg_q <= acc_neg;
      tneg_q <= item_i.neg;
    end
    if (o_en && r_vld_q) begin
      ang_q <= ang_d;
    end
  end

  assign valid_o     = o_vld_q;
  assign angle_deg_o = $signed(ang_q);

endmodule

// ----- design/polynomial_arctan_degrees.sv -----
// ----------------------------------------------------------------------------
// polynomial_arctan_degrees
// arctangent in degrees by piecewise Horner polynomials on a chain of cells
// ----------------------------------------------------------------------------
// path from accepted tangent to angle: input stage, five cells of two stages
// each, round stage, output register; throughput is one item per cycle while
// out_stall_i is low, set by the fully pipelined Horner cell chain
// reset clears all valid flags; payload registers are not reset
// ----------------------------------------------------------------------------
module polynomial_arctan_degrees #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [polyarc_pkg::IN_W-1:0]  tangent_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [polyarc_pkg::OUT_W-1:0] angle_deg_o
);

  localparam int unsigned LOW_LIM = 32'd4 << FRAC_BITS;

  logic                    in_vld_q;
  logic                    in_en;
  polyarc_pkg::item_t      in_item_d;
  polyarc_pkg::item_t      in_item_q;

  logic                    vld   [polyarc_pkg::STEPS+1];
  logic                    stl   [polyarc_pkg::STEPS+1];
  polyarc_pkg::item_t      itm   [polyarc_pkg::STEPS+1];

  assign in_en      = !in_vld_q || !stl[0];
  assign in_stall_o = !in_en;

  always_comb begin
    in_item_d.neg  = tangent_i[polyarc_pkg::IN_W-1];
    in_item_d.mag  = in_item_d.neg ? polyarc_pkg::MAG_W'(-tangent_i)
                                   : polyarc_pkg::MAG_W'(tangent_i);
    in_item_d.high = 32'(in_item_d.mag) > LOW_LIM;
    in_item_d.acc  = in_item_d.high ? polyarc_pkg::HIGH_LEAD : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_en) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en && in_valid_i) begin
      in_item_q <= in_item_d;
    end
  end

  assign vld[0] = in_vld_q;
  assign itm[0] = in_item_q;

  for (genvar k = 0; k < polyarc_pkg::STEPS; k++) begin : g_cell
    polyarc_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .valid_i     (vld[k]),
      .stall_o     (stl[k]),
      .item_i      (itm[k]),
      .coef_low_i  (polyarc_pkg::COEF_LOW[k]),
      .coef_high_i (polyarc_pkg::COEF_HIGH[k]),
      .valid_o     (vld[k+1]),
      .stall_i     (stl[k+1]),
      .item_o      (itm[k+1])
    );
  end

  polyarc_finish #(
    .FRAC_BITS (FRAC_BITS)
  ) u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld[polyarc_pkg::STEPS]),
    .stall_o     (stl[polyarc_pkg::STEPS]),
    .item_i      (itm[polyarc_pkg::STEPS]),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .angle_deg_o (angle_deg_o)
  );

endmodule

// ----- design/polyarc_checker.sv -----
// ----------------------------------------------------------------------------
// polyarc_checker
// port-level checks on the arctangent block, bound to the top level
// ----------------------------------------------------------------------------
`include "polynomial_arctan_degrees_defines.svh"

module polyarc_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [polyarc_pkg::IN_W-1:0]  tangent_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [polyarc_pkg::OUT_W-1:0] angle_deg_o
);

  localparam int RIGHT   = 90 << FRAC_BITS;
  localparam int OUT_TOP = (1 << (polyarc_pkg::OUT_W - 1)) - 1;
  localparam logic signed [polyarc_pkg::OUT_W-1:0] LIM_P =
    polyarc_pkg::OUT_W'((RIGHT > OUT_TOP) ? OUT_TOP : RIGHT);
  localparam logic signed [polyarc_pkg::OUT_W-1:0] LIM_N =
    polyarc_pkg::OUT_W'((RIGHT > OUT_TOP) ? -OUT_TOP - 1 : -RIGHT);

  logic in_seen;
  logic out_held;
  logic out_in_range;
  assign in_seen      = in_valid_i && !in_stall_o;
  assign out_held     = out_valid_o && out_stall_i;
  assign out_in_range = (angle_deg_o <= LIM_P) && (angle_deg_o >= LIM_N);

  `PAD_ASSERT(a_out_hold, out_held |=> out_valid_o, "item dropped under stall")
  `PAD_ASSERT(a_out_stable, out_held |=> $stable(angle_deg_o), "payload moved under stall")
  `PAD_ASSERT(a_range, out_valid_o |-> out_in_range, "angle beyond right angle")
  `PAD_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "output valid in reset")
  `PAD_ASSERT(a_accept_known, in_seen |-> !$isunknown(tangent_i), "accepted tangent unknown")

endmodule

bind polynomial_arctan_degrees polyarc_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_polyarc_checker (.*);

// ----- tb/polyarc_angle_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyarc_angle_checker
// watches both channels of the arctangent block, predicts the angle of every
// accepted tangent in fixed point and compares it with the next angle out
// ----------------------------------------------------------------------------
module polyarc_angle_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [polyarc_pkg::IN_W-1:0]  tangent_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [polyarc_pkg::OUT_W-1:0] angle_deg_i,
  output int                                   mismatch_count_o,
  output int                                   pending_count_o
);

  localparam int     IN_W     = polyarc_pkg::IN_W;
  localparam int     OUT_W    = polyarc_pkg::OUT_W;
  localparam int     SHIFT    = 32 - FRAC_BITS;
  localparam longint ACC_CEIL = longint'(4096) << 32;
  localparam longint ANG_MAX  = longint'(90) << FRAC_BITS;
  localparam longint OUT_MAX  = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN  = -(longint'(1) << (OUT_W - 1));

  longint                    low_coefs[5];
  longint                    high_coefs[6];
  logic signed [OUT_W-1:0]   expected_angles[$];

  // decimal fraction num/den with 32 fraction bits, rounded to nearest
  function automatic longint q32(input longint unsigned num, input longint unsigned den);
    return longint'((num * 64'd4294967296 + den / 2) / den);
  endfunction

  function automatic longint horner_step(input longint acc, input longint unsigned t,
                                         input longint coef);
    logic [127:0]      prod;
    logic [127:0]      scaled;
    longint unsigned   m;
    longint            r;
    m = (acc < 0) ? longint'(-acc) : acc;
    prod = {64'd0, m} * {64'd0, t};
    scaled = prod >> FRAC_BITS;
    r = longint'(scaled[63:0]);
    if (acc < 0) r = -r;
    r = r + coef;
    if (r > ACC_CEIL) r = ACC_CEIL;
    if (r < -ACC_CEIL) r = -ACC_CEIL;
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] arctan_angle(input logic signed [IN_W-1:0] tan);
    longint unsigned mag;
    longint          acc;
    longint          ang;
    longint          half;
    logic            neg;
    logic [63:0]     bits;
    neg = tan[IN_W-1];
    mag = neg ? longint'(-longint'(tan)) : longint'(tan);
    half = longint'(1) << (SHIFT - 1);
    if (mag <= (64'd4 << FRAC_BITS)) begin
      acc = low_coefs[0];
      for (int i = 1; i < 5; i++) acc = horner_step(acc, mag, low_coefs[i]);
    end else begin
      acc = high_coefs[0];
      for (int i = 1; i < 6; i++) acc = horner_step(acc, mag, high_coefs[i]);
    end
    if (acc >= 0) ang = (acc + half) >>> SHIFT;
    else ang = -((-acc + half) >>> SHIFT);
    if (ang > ANG_MAX) ang = ANG_MAX;
    if (neg) ang = -ang;
    if (ang > OUT_MAX) ang = OUT_MAX;
    if (ang < OUT_MIN) ang = OUT_MIN;
    bits = ang;
    return bits[OUT_W-1:0];
  endfunction

  initial begin
    low_coefs[0]  = -q32(64'd30269379, 64'd100000000);
    low_coefs[1]  =  q32(64'd42937098, 64'd10000000);
    low_coefs[2]  = -q32(64'd236768389, 64'd10000000);
    low_coefs[3]  =  q32(64'd643918945, 64'd10000000);
    low_coefs[4]  = 0;
    high_coefs[0] =  q32(64'd2148232, 64'd100000000000);
    high_coefs[1] = -q32(64'd1763455, 64'd1000000000);
    high_coefs[2] =  q32(64'd57272137, 64'd1000000000);
    high_coefs[3] = -q32(64'd93504677, 64'd100000000);
    high_coefs[4] =  q32(64'd8036428, 64'd1000000);
    high_coefs[5] =  q32(64'd55625009, 64'd1000000);
    mismatch_count_o = 0;
    pending_count_o  = 0;
  end

  always @(posedge clk_i) begin : watch
    logic signed [OUT_W-1:0] want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_angles.push_back(arctan_angle(tangent_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_angles.size() == 0) begin
          $error("angle_deg: expected no item, actual %0d", angle_deg_i);
          mismatch_count_o++;
        end else begin
          want = expected_angles.pop_front();
          if (angle_deg_i !== want) begin
            $error("angle_deg: expected %0d, actual %0d", want, angle_deg_i);
            mismatch_count_o++;
          end
        end
      end
      pending_count_o = expected_angles.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives tangents into the arctangent block with random gaps and stalls,
// a long output hold-off and a calm stretch, and reports the verdict
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC_BITS    = 16;
  localparam int RANDOM_ITEMS = 1550;
  localparam int RUN_LIMIT    = 400000;
  localparam int HOLD_FROM    = 400;
  localparam int HOLD_CYCLES  = 300;

  localparam logic signed [polyarc_pkg::IN_W-1:0] DIRECTED_TANGENTS[19] = '{
    24'sh000000, 24'sh000001, 24'shFFFFFF, 24'sh010000, 24'shFF0000,
    24'sh03FFFF, 24'sh040000, 24'sh040001, 24'shFC0000, 24'shFBFFFF,
    24'sh7FFFFF, 24'sh800000, 24'sh800001, 24'sh100000, 24'sh5A0000,
    24'sh555555, 24'shAAAAAA, 24'sh00FFFF, 24'sh001000
  };

  logic                                 clk_i     = 1'b0;
  logic                                 rst_ni;
  logic                                 in_valid  = 1'b0;
  logic                                 in_stall;
  logic signed [polyarc_pkg::IN_W-1:0]  tangent   = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic signed [polyarc_pkg::OUT_W-1:0] angle_deg;
  int                                   mismatch_count;
  int                                   pending_count;
  int                                   cycle_count = 0;
  bit                                   calm = 1'b0;

  always #5 clk_i = ~clk_i;

  polynomial_arctan_degrees #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .tangent_i  (tangent),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .angle_deg_o(angle_deg)
  );

  polyarc_angle_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .tangent_i       (tangent),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .angle_deg_i     (angle_deg),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off so the pipe backs up
  initial begin : receiver
    int rcv_cycle;
    rcv_cycle = 0;
    forever begin
      @(negedge clk_i);
      rcv_cycle++;
      if (rcv_cycle >= HOLD_FROM && rcv_cycle < HOLD_FROM + HOLD_CYCLES) out_stall <= 1'b1;
      else if (calm) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < 34);
    end
  end

  task automatic send_tangent(input logic signed [polyarc_pkg::IN_W-1:0] value);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    tangent  <= value;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  function automatic logic signed [polyarc_pkg::IN_W-1:0] random_tangent();
    int unsigned pick;
    int unsigned mag;
    pick = $urandom_range(99);
    if (pick < 40) return polyarc_pkg::IN_W'($urandom());
    if (pick < 65) mag = $urandom_range(32'h48000);
    else if (pick < 85) mag = $urandom_range(32'h400000, 32'h40000);
    else if (pick < 95) mag = 32'h40000 - 8 + $urandom_range(16);
    else mag = 32'h800000 - $urandom_range(64);
    return polyarc_pkg::IN_W'($urandom_range(1) ? -mag : mag);
  endfunction

  initial begin : stimulus
    int n;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DIRECTED_TANGENTS[k]) send_tangent(DIRECTED_TANGENTS[k]);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      send_tangent(random_tangent());
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
